// ===== sv/kirt_pkg.sv =====
package kirt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int KEY_W  = 31;
   localparam int POS_W  = 16;
   localparam int MASK_W = 32;
   localparam int OP_W   = 2;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 40;

   localparam logic [OP_W-1:0] OP_SET    = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]         key;
      logic signed [POS_W-1:0]  low;
      logic signed [POS_W-1:0]  high;
      logic [MASK_W-1:0]        mask;
   } entry_type;

   // compare unit result for one stored entry against the query range
   typedef struct packed {
      logic key_eq;
      logic overlap;
      logic left;
      logic right;
   } cmp_res_type;

endpackage

// ===== sv/keyed_interval_range_table.sv =====
// Keyed interval range table. An item carries an operation in req_tuser:
// set (0) cuts the new range out of every overlapping entry of the same key
// and appends it, lookup (1) returns the mask of the first entry of the key
// whose range holds range_low, clear (2) empties the table; code 3 does
// nothing. Exactly one result follows each item. One item is in work at a
// time: entries pass a single compare unit one per cycle, a split entry
// taking an extra step, read from a bank with a read and a write port. A
// lookup stops at its first hit; a set walks all entries, then appends.
// A set rebuilds into the spare bank, which becomes current only if the new
// table fits; otherwise status reports full and the table is unchanged.
module keyed_interval_range_table
   import kirt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key[30:0], range_low[46:31], range_high[62:47], event_mask[94:63], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found[0], mask_out[32:1], status[33], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOOK  = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_SPLIT = 3'd3;
   localparam logic [2:0] ST_NEW   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

   logic [2:0]              state_ff,     state_in;
   logic [IDX_W-1:0]        idx_ff,       idx_in;
   logic [CNT_W-1:0]        count_ff,     count_in;
   logic [CNT_W-1:0]        wcnt_ff,      wcnt_in;
   logic                    cur_bank_ff,  cur_bank_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;

   logic [KEY_W-1:0]        key_ff;
   logic signed [POS_W-1:0] lo_ff;
   logic signed [POS_W-1:0] hi_ff;
   logic [MASK_W-1:0]       mask_ff;
   logic                    found_ff,  found_in;
   logic [MASK_W-1:0]       mout_ff,   mout_in;
   logic                    status_ff, status_in;

   logic [OP_W-1:0]         req_op;
   logic [KEY_W-1:0]        req_key;
   logic signed [POS_W-1:0] req_low;
   logic signed [POS_W-1:0] req_high;
   logic [MASK_W-1:0]       req_mask;
   logic signed [POS_W-1:0] lo_load;
   logic signed [POS_W-1:0] hi_load;

   logic                    accept;
   logic                    rsp_load;
   logic                    last;
   logic [IDX_W-1:0]        rd_addr;
   entry_type               rd_data;
   entry_type               rd_data0;
   entry_type               rd_data1;
   cmp_res_type             cmp;
   logic                    keep;
   logic                    split;
   logic                    put;
   entry_type               put_data;
   entry_type               left_piece;
   entry_type               right_piece;
   entry_type               new_entry;
   logic                    ovf;
   logic                    wr_en;

   assign req_op   = req_tuser;
   assign req_key  = req_tdata[30:0];
   assign req_low  = $signed(req_tdata[46:31]);
   assign req_high = $signed(req_tdata[62:47]);
   assign req_mask = req_tdata[94:63];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // lookup checks a single point: hi = lo turns the overlap test into a hit test
   always_comb begin
      lo_load = req_low;
      hi_load = req_high;
      if (req_op == OP_LOOKUP) begin
         hi_load = req_low;
      end else if (req_low > req_high) begin
         lo_load = req_high;
         hi_load = req_low;
      end
   end

   assign rd_data = cur_bank_ff ? rd_data1 : rd_data0;

   kirt_bank u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && cur_bank_ff),
      .wr_addr (wcnt_ff[IDX_W-1:0]),
      .wr_data (put_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   kirt_bank u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && !cur_bank_ff),
      .wr_addr (wcnt_ff[IDX_W-1:0]),
      .wr_data (put_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   kirt_cmp u_cmp (
      .ent (rd_data),
      .key (key_ff),
      .lo  (lo_ff),
      .hi  (hi_ff),
      .res (cmp)
   );

   assign keep  = !cmp.key_eq || !cmp.overlap;
   assign split = !keep && cmp.left && cmp.right;
   assign last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      left_piece      = rd_data;
      left_piece.high = lo_ff - POS_W'(1);
      right_piece     = rd_data;
      right_piece.low = hi_ff + POS_W'(1);
      new_entry.key   = key_ff;
      new_entry.low   = lo_ff;
      new_entry.high  = hi_ff;
      new_entry.mask  = mask_ff;
   end

   // what goes into the spare bank this cycle
   always_comb begin
      put      = 1'b0;
      put_data = rd_data;
      case (state_ff)
         ST_RUN: begin
            if (keep) begin
               put = 1'b1;
            end else if (cmp.left) begin
               put      = 1'b1;
               put_data = left_piece;
            end else if (cmp.right) begin
               put      = 1'b1;
               put_data = right_piece;
            end
         end
         ST_SPLIT: begin
            put      = 1'b1;
            put_data = right_piece;
         end
         ST_NEW: begin
            put      = 1'b1;
            put_data = new_entry;
         end
         default: begin
            put = 1'b0;
         end
      endcase
   end

   assign ovf   = put && (wcnt_ff == FULL_CNT);
   assign wr_en = put && !ovf;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      wcnt_in     = wcnt_ff;
      cur_bank_in = cur_bank_ff;
      found_in    = found_ff;
      mout_in     = mout_ff;
      status_in   = status_ff;
      rd_addr     = idx_ff;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (accept) begin
               idx_in    = '0;
               wcnt_in   = '0;
               found_in  = 1'b0;
               mout_in   = '0;
               status_in = 1'b0;
               case (req_op)
                  OP_SET: begin
                     state_in = (count_ff == '0) ? ST_NEW : ST_RUN;
                  end
                  OP_LOOKUP: begin
                     state_in = (count_ff == '0) ? ST_DONE : ST_LOOK;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (cmp.key_eq && cmp.overlap) begin
               found_in = 1'b1;
               mout_in  = rd_data.mask;
               state_in = ST_DONE;
            end else if (last) begin
               state_in = ST_DONE;
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               rd_addr = idx_ff + IDX_W'(1);
            end
         end
         ST_RUN: begin
            if (ovf) begin
               status_in = 1'b1;
               state_in  = ST_DONE;
            end else if (split) begin
               wcnt_in  = wcnt_ff + CNT_W'(1);
               state_in = ST_SPLIT;
            end else begin
               if (put) begin
                  wcnt_in = wcnt_ff + CNT_W'(1);
               end
               if (last) begin
                  state_in = ST_NEW;
               end else begin
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_addr = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_SPLIT: begin
            if (ovf) begin
               status_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               wcnt_in = wcnt_ff + CNT_W'(1);
               if (last) begin
                  state_in = ST_NEW;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  rd_addr  = idx_ff + IDX_W'(1);
                  state_in = ST_RUN;
               end
            end
         end
         ST_NEW: begin
            if (ovf) begin
               status_in = 1'b1;
            end else begin
               count_in    = wcnt_ff + CNT_W'(1);
               cur_bank_in = !cur_bank_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_bank_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_bank_ff  <= cur_bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      wcnt_ff   <= wcnt_in;
      found_ff  <= found_in;
      mout_ff   <= mout_in;
      status_ff <= status_in;
      if (accept) begin
         key_ff  <= req_key;
         lo_ff   <= lo_load;
         hi_ff   <= hi_load;
         mask_ff <= req_mask;
      end
      if (rsp_load) begin
         rsp_data_ff <= {6'd0, status_ff, mout_ff, found_ff};
      end
   end

endmodule

// ===== sv/kirt_cmp.sv =====
module kirt_cmp
   import kirt_pkg::*;
(
   input  entry_type                ent,
   input  logic [KEY_W-1:0]         key,
   input  logic signed [POS_W-1:0]  lo,
   input  logic signed [POS_W-1:0]  hi,
   output cmp_res_type              res
);

   logic signed [POS_W-1:0] ent_low;
   logic signed [POS_W-1:0] ent_high;

   assign ent_low  = $signed(ent.low);
   assign ent_high = $signed(ent.high);

   assign res.key_eq  = (ent.key == key);
   assign res.overlap = !((ent_high < lo) || (ent_low > hi));
   assign res.left    = (ent_low < lo);
   assign res.right   = (ent_high > hi);

endmodule

// ===== sv/kirt_bank.sv =====
module kirt_bank
   import kirt_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
